// ----- src/rbv_pkg.sv -----
// rbv_pkg: shared types, widths and constants of the rotation-between-vectors block
package rbv_pkg;

   typedef logic signed [15:0] comp_type;

   // unit-vector stage: radicand |v|^2 << 30, length, quotient
   localparam int RAD_A_W = 62;
   localparam int LEN_W   = RAD_A_W / 2;
   localparam int UQ_W    = 17;
   localparam int UNUM_W  = 47;

   // quaternion stage: radicand (2(1+c) or m2) << 30, root, quotient
   localparam int RAD_B_W = 64;
   localparam int ROOT_W  = RAD_B_W / 2;
   localparam int QQ_W    = 21;
   localparam int QNUM_W  = 47;
   localparam int QMAG_W  = 46;

   localparam logic signed [17:0] U_MAX   = 18'sd32768;
   localparam logic signed [21:0] Q_MAX   = 22'sd16384;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;
   localparam logic signed [32:0] C_MAX   = 33'sd1073741824;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [42:0] OPP_LIMIT = -43'sd1072668082176;
   localparam logic [39:0] AXIS_LIMIT = 40'd1073741824;

   typedef struct packed {
      logic [5:0][15:0] vec;
      logic             zero;
   } side_a_type;

   typedef struct packed {
      logic [5:0] neg;
      logic       zero;
   } side_u_type;

   typedef struct packed {
      logic [2:0][QMAG_W-1:0] mag;
      logic [2:0]             neg;
      logic                   opp;
      logic                   zero;
   } side_b_type;

   typedef struct packed {
      logic [2:0]  neg;
      logic        opp;
      logic        zero;
      logic        den_zero;
      logic [15:0] w;
   } side_d_type;

endpackage

// ----- src/rbv_if.sv -----
// rbv_if: request and response channel interfaces
interface rbv_req_if;
   import rbv_pkg::*;
   logic     valid;
   logic     ready;
   comp_type start_x;
   comp_type start_y;
   comp_type start_z;
   comp_type dest_x;
   comp_type dest_y;
   comp_type dest_z;
   modport source(output valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                  input ready);
   modport sink(input valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                output ready);
endinterface

interface rbv_rsp_if;
   import rbv_pkg::*;
   logic     valid;
   logic     ready;
   comp_type quat_w;
   comp_type quat_x;
   comp_type quat_y;
   comp_type quat_z;
   logic     opposite_case;
   logic     zero_input;
   modport source(output valid, quat_w, quat_x, quat_y, quat_z, opposite_case, zero_input,
                  input ready);
   modport sink(input valid, quat_w, quat_x, quat_y, quat_z, opposite_case, zero_input,
                output ready);
endinterface

// ----- src/rbv_delay.sv -----
// rbv_delay: valid and sideband delay line matched to a pipelined unit
module rbv_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             vld_out,
   output logic [WIDTH-1:0] data_out
);
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff[0] <= vld_in;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign vld_out  = vld_ff[DEPTH-1];
   assign data_out = data_ff[DEPTH-1];
endmodule

// ----- src/rbv_sqrt_pipe.sv -----
// rbv_sqrt_pipe: floor square root, one result bit per pipeline stage
module rbv_sqrt_pipe #(
   parameter int IN_W = 62
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);
   localparam int OUT_W = IN_W / 2;
   localparam logic [IN_W:0]    REM_ONE  = 1;
   localparam logic [OUT_W-1:0] ROOT_ONE = 1;

   logic [IN_W:0]    rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];

   for (genvar i = 0; i < OUT_W; i++) begin : g_stage
      localparam int K = OUT_W - 1 - i;
      logic [IN_W:0]    rem_prev;
      logic [IN_W:0]    trial;
      logic [IN_W:0]    rem_in;
      logic [OUT_W-1:0] root_prev;
      logic [OUT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign rem_prev  = {1'b0, radicand};
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^2k
      assign trial = ((IN_W+1)'(root_prev) << (K + 1)) | (REM_ONE << (2 * K));

      always_comb begin
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_ONE << K);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   assign root = root_ff[OUT_W-1];
endmodule

// ----- src/rbv_div_pipe.sv -----
// rbv_div_pipe: unsigned restoring divider, one quotient bit per pipeline stage
module rbv_div_pipe #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 31,
   parameter int QUO_W = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
   localparam logic [QUO_W-1:0] Q_ONE = 1;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int K = QUO_W - 1 - i;
      logic [REM_W-1:0] rem_prev;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] rem_in;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [QUO_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = REM_W'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign shifted = REM_W'(den_prev) << K;

      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= shifted) begin
            rem_in = rem_prev - shifted;
            quo_in = quo_prev | (Q_ONE << K);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];
endmodule

// ----- src/rotation_between_vectors_top.sv -----
// rotation_between_vectors_top: pipelined shortest-arc quaternion from two vectors
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    start_x/y/z, dest_x/y/z (signed 16)
//   rsp_ch   out  valid/ready    quat_w/x/y/z (signed Q1.14), opposite_case, zero_input
//
// one transaction accepted per cycle while the output register is empty or rsp_ch.ready is high
// the pipeline runs through two bit-per-stage square roots (31 and 32 stages) and two
// bit-per-stage dividers (17 and 21 stages) in series
// reset is synchronous and clears only the valid bits
// a stalled output register freezes the whole pipeline; nothing is dropped or repeated
module rotation_between_vectors_top (
   input logic        clock,
   input logic        reset,
   rbv_req_if.sink    req_ch,
   rbv_rsp_if.source  rsp_ch
);
   import rbv_pkg::*;

   localparam int SQA_LAT = RAD_A_W / 2;
   localparam int SQB_LAT = RAD_B_W / 2;

   function automatic logic [30:0] sq16(input logic signed [15:0] a);
      logic signed [31:0] p;
      p = 32'(a) * 32'(a);
      return p[30:0];
   endfunction

   function automatic logic signed [31:0] mul17(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
      logic signed [33:0] p;
      p = 34'(a) * 34'(b);
      return p[31:0];
   endfunction

   logic en;
   logic out_vld_ff;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: capture and square
   comp_type in_vec [6];
   assign in_vec[0] = req_ch.start_x;
   assign in_vec[1] = req_ch.start_y;
   assign in_vec[2] = req_ch.start_z;
   assign in_vec[3] = req_ch.dest_x;
   assign in_vec[4] = req_ch.dest_y;
   assign in_vec[5] = req_ch.dest_z;

   logic        s1_vld_ff;
   comp_type    s1_vec_ff [6];
   logic [30:0] s1_sq_ff  [6];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            s1_vec_ff[i] <= in_vec[i];
            s1_sq_ff[i]  <= sq16(in_vec[i]);
         end
      end
   end

   // stage 2: squared lengths
   logic               s2_vld_ff;
   logic [RAD_A_W-1:0] s2_rad_s_ff;
   logic [RAD_A_W-1:0] s2_rad_d_ff;
   side_a_type         s2_side_ff;
   logic [31:0]        n2_s;
   logic [31:0]        n2_d;
   side_a_type         side_a_in;

   always_comb begin
      n2_s = 32'(s1_sq_ff[0]) + 32'(s1_sq_ff[1]) + 32'(s1_sq_ff[2]);
      n2_d = 32'(s1_sq_ff[3]) + 32'(s1_sq_ff[4]) + 32'(s1_sq_ff[5]);
      for (int i = 0; i < 6; i++) side_a_in.vec[i] = s1_vec_ff[i];
      side_a_in.zero = (n2_s == '0) || (n2_d == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_rad_s_ff <= {n2_s, 30'b0};
         s2_rad_d_ff <= {n2_d, 30'b0};
         s2_side_ff  <= side_a_in;
      end
   end

   // vector lengths
   logic [LEN_W-1:0] len_s;
   logic [LEN_W-1:0] len_d;
   logic             a_vld;
   side_a_type       a_side;

   rbv_sqrt_pipe #(.IN_W(RAD_A_W)) u_sqrt_s (
      .clock(clock), .en(en), .radicand(s2_rad_s_ff), .root(len_s));
   rbv_sqrt_pipe #(.IN_W(RAD_A_W)) u_sqrt_d (
      .clock(clock), .en(en), .radicand(s2_rad_d_ff), .root(len_d));
   rbv_delay #(.WIDTH($bits(side_a_type)), .DEPTH(SQA_LAT)) u_dly_a (
      .clock(clock), .reset(reset), .en(en), .vld_in(s2_vld_ff), .data_in(s2_side_ff),
      .vld_out(a_vld), .data_out(a_side));

   // stage 3: rounded numerators for the unit vectors
   logic              s3_vld_ff;
   logic [UNUM_W-1:0] s3_num_ff [6];
   logic [LEN_W-1:0]  s3_len_s_ff;
   logic [LEN_W-1:0]  s3_len_d_ff;
   side_u_type        s3_side_ff;
   logic [UNUM_W-1:0] unum_in [6];
   logic [15:0]       vmag    [6];
   side_u_type        side_u_in;
   comp_type          vcomp   [6];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         vcomp[i]         = $signed(a_side.vec[i]);
         side_u_in.neg[i] = vcomp[i] < 0;
         vmag[i]          = side_u_in.neg[i] ? 16'(-vcomp[i]) : a_side.vec[i];
         unum_in[i]       = UNUM_W'({vmag[i], 30'b0})
                          + UNUM_W'((i < 3) ? (len_s >> 1) : (len_d >> 1));
      end
      side_u_in.zero = a_side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= a_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) s3_num_ff[i] <= unum_in[i];
         s3_len_s_ff <= len_s;
         s3_len_d_ff <= len_d;
         s3_side_ff  <= side_u_in;
      end
   end

   logic [UQ_W-1:0] uq [6];
   logic            u_vld;
   side_u_type      u_side;

   for (genvar i = 0; i < 6; i++) begin : g_udiv
      rbv_div_pipe #(.NUM_W(UNUM_W), .DEN_W(LEN_W), .QUO_W(UQ_W)) u_div (
         .clock(clock), .en(en), .num(s3_num_ff[i]),
         .den((i < 3) ? s3_len_s_ff : s3_len_d_ff), .quo(uq[i]));
   end

   rbv_delay #(.WIDTH($bits(side_u_type)), .DEPTH(UQ_W)) u_dly_u (
      .clock(clock), .reset(reset), .en(en), .vld_in(s3_vld_ff), .data_in(s3_side_ff),
      .vld_out(u_vld), .data_out(u_side));

   // stage 4: signed, clamped Q15 unit vectors
   logic                s4_vld_ff;
   logic signed [16:0]  s4_u_ff [6];
   logic                s4_zero_ff;
   logic signed [17:0]  usgn    [6];
   logic signed [16:0]  u_in    [6];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         usgn[i] = u_side.neg[i] ? -$signed({1'b0, uq[i]}) : $signed({1'b0, uq[i]});
         if (usgn[i] > U_MAX) u_in[i] = U_MAX[16:0];
         else if (usgn[i] < -U_MAX) u_in[i] = 17'(-U_MAX);
         else u_in[i] = usgn[i][16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= u_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) s4_u_ff[i] <= u_in[i];
         s4_zero_ff <= u_side.zero;
      end
   end

   // stage 5: products for dot, cross and axis lengths
   logic               s5_vld_ff;
   logic signed [31:0] s5_p_ff [12];
   logic signed [16:0] s5_u_ff [3];
   logic               s5_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_p_ff[0]  <= mul17(s4_u_ff[0], s4_u_ff[3]);
         s5_p_ff[1]  <= mul17(s4_u_ff[1], s4_u_ff[4]);
         s5_p_ff[2]  <= mul17(s4_u_ff[2], s4_u_ff[5]);
         s5_p_ff[3]  <= mul17(s4_u_ff[1], s4_u_ff[5]);
         s5_p_ff[4]  <= mul17(s4_u_ff[2], s4_u_ff[4]);
         s5_p_ff[5]  <= mul17(s4_u_ff[2], s4_u_ff[3]);
         s5_p_ff[6]  <= mul17(s4_u_ff[0], s4_u_ff[5]);
         s5_p_ff[7]  <= mul17(s4_u_ff[0], s4_u_ff[4]);
         s5_p_ff[8]  <= mul17(s4_u_ff[1], s4_u_ff[3]);
         s5_p_ff[9]  <= mul17(s4_u_ff[0], s4_u_ff[0]);
         s5_p_ff[10] <= mul17(s4_u_ff[1], s4_u_ff[1]);
         s5_p_ff[11] <= mul17(s4_u_ff[2], s4_u_ff[2]);
         for (int i = 0; i < 3; i++) s5_u_ff[i] <= s4_u_ff[i];
         s5_zero_ff <= s4_zero_ff;
      end
   end

   // stage 6: sums
   logic               s6_vld_ff;
   logic signed [32:0] s6_c_ff;
   logic signed [32:0] s6_a_ff [3];
   logic [31:0]        s6_m2a_ff;
   logic [31:0]        s6_m2b_ff;
   logic signed [16:0] s6_u_ff [3];
   logic               s6_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (en) s6_vld_ff <= s5_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_c_ff    <= 33'(s5_p_ff[0]) + 33'(s5_p_ff[1]) + 33'(s5_p_ff[2]);
         s6_a_ff[0] <= 33'(s5_p_ff[3]) - 33'(s5_p_ff[4]);
         s6_a_ff[1] <= 33'(s5_p_ff[5]) - 33'(s5_p_ff[6]);
         s6_a_ff[2] <= 33'(s5_p_ff[7]) - 33'(s5_p_ff[8]);
         s6_m2a_ff  <= 32'(s5_p_ff[9]) + 32'(s5_p_ff[10]);
         s6_m2b_ff  <= 32'(s5_p_ff[10]) + 32'(s5_p_ff[11]);
         for (int i = 0; i < 3; i++) s6_u_ff[i] <= s5_u_ff[i];
         s6_zero_ff <= s5_zero_ff;
      end
   end

   // stage 7: clamp c, pick the half-turn axis candidate
   logic               s7_vld_ff;
   logic signed [31:0] s7_c_ff;
   logic signed [32:0] s7_a_ff  [3];
   logic signed [16:0] s7_ax_ff [3];
   logic [31:0]        s7_m2_ff;
   logic               s7_zero_ff;
   logic signed [31:0] c_clamp;
   logic               axis_short;

   always_comb begin
      if (s6_c_ff > C_MAX) c_clamp = C_MAX[31:0];
      else if (s6_c_ff < -C_MAX) c_clamp = 32'(-C_MAX);
      else c_clamp = s6_c_ff[31:0];
      // z cross start too short: fall back to x cross start
      axis_short = (40'(s6_m2a_ff) * 40'd100) < AXIS_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (en) s7_vld_ff <= s6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_c_ff <= c_clamp;
         for (int i = 0; i < 3; i++) s7_a_ff[i] <= s6_a_ff[i];
         if (axis_short) begin
            s7_ax_ff[0] <= '0;
            s7_ax_ff[1] <= -s6_u_ff[2];
            s7_ax_ff[2] <= s6_u_ff[1];
            s7_m2_ff    <= s6_m2b_ff;
         end else begin
            s7_ax_ff[0] <= -s6_u_ff[1];
            s7_ax_ff[1] <= s6_u_ff[0];
            s7_ax_ff[2] <= '0;
            s7_m2_ff    <= s6_m2a_ff;
         end
         s7_zero_ff <= s6_zero_ff;
      end
   end

   // stage 8: opposite test, radicand and numerator magnitudes
   logic               s8_vld_ff;
   logic [RAD_B_W-1:0] s8_rad_ff;
   side_b_type         s8_side_ff;
   logic signed [42:0] c1000;
   logic signed [33:0] tsum;
   logic               opp;
   logic [RAD_B_W-1:0] rad_b_in;
   side_b_type         side_b_in;
   logic signed [32:0] nsrc [3];
   logic [31:0]        nabs [3];

   always_comb begin
      c1000 = 43'(s7_c_ff) * 43'sd1000;
      opp   = c1000 < OPP_LIMIT;
      tsum  = 34'(s7_c_ff) + ONE_Q30;
      if (opp) rad_b_in = {2'b0, s7_m2_ff, 30'b0};
      else rad_b_in = {1'b0, tsum[31:0], 1'b0, 30'b0};
      for (int i = 0; i < 3; i++) begin
         nsrc[i]          = opp ? 33'(s7_ax_ff[i]) : s7_a_ff[i];
         side_b_in.neg[i] = nsrc[i] < 0;
         nabs[i]          = side_b_in.neg[i] ? 32'(-nsrc[i]) : nsrc[i][31:0];
         side_b_in.mag[i] = opp ? QMAG_W'({nabs[i][15:0], 29'b0})
                                : QMAG_W'({nabs[i], 14'b0});
      end
      side_b_in.opp  = opp;
      side_b_in.zero = s7_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s8_vld_ff <= 1'b0;
      else if (en) s8_vld_ff <= s7_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_rad_ff  <= rad_b_in;
         s8_side_ff <= side_b_in;
      end
   end

   logic [ROOT_W-1:0] s30;
   logic              b_vld;
   side_b_type        b_side;

   rbv_sqrt_pipe #(.IN_W(RAD_B_W)) u_sqrt_q (
      .clock(clock), .en(en), .radicand(s8_rad_ff), .root(s30));
   rbv_delay #(.WIDTH($bits(side_b_type)), .DEPTH(SQB_LAT)) u_dly_b (
      .clock(clock), .reset(reset), .en(en), .vld_in(s8_vld_ff), .data_in(s8_side_ff),
      .vld_out(b_vld), .data_out(b_side));

   // stage 9: rounded numerators and w
   logic              s9_vld_ff;
   logic [QNUM_W-1:0] s9_num_ff [3];
   logic [ROOT_W-1:0] s9_den_ff;
   side_d_type        s9_side_ff;
   logic [ROOT_W:0]   w_sum;
   side_d_type        side_d_in;

   always_comb begin
      w_sum              = (ROOT_W+1)'(s30) + (ROOT_W+1)'(17'h10000);
      side_d_in.neg      = b_side.neg;
      side_d_in.opp      = b_side.opp;
      side_d_in.zero     = b_side.zero;
      side_d_in.den_zero = s30 == '0;
      side_d_in.w        = w_sum[32:17];
   end

   always_ff @(posedge clock) begin
      if (reset) s9_vld_ff <= 1'b0;
      else if (en) s9_vld_ff <= b_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            s9_num_ff[i] <= QNUM_W'(b_side.mag[i]) + QNUM_W'(s30 >> 1);
         s9_den_ff  <= s30;
         s9_side_ff <= side_d_in;
      end
   end

   logic [QQ_W-1:0] qq [3];
   logic            d_vld;
   side_d_type      d_side;

   for (genvar i = 0; i < 3; i++) begin : g_qdiv
      rbv_div_pipe #(.NUM_W(QNUM_W), .DEN_W(ROOT_W), .QUO_W(QQ_W)) u_div (
         .clock(clock), .en(en), .num(s9_num_ff[i]), .den(s9_den_ff), .quo(qq[i]));
   end

   rbv_delay #(.WIDTH($bits(side_d_type)), .DEPTH(QQ_W)) u_dly_d (
      .clock(clock), .reset(reset), .en(en), .vld_in(s9_vld_ff), .data_in(s9_side_ff),
      .vld_out(d_vld), .data_out(d_side));

   // output register
   comp_type           quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic               opp_ff, zero_ff;
   logic signed [21:0] qsgn   [3];
   comp_type           xyz_in [3];
   comp_type           w_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qsgn[i] = d_side.neg[i] ? -$signed({1'b0, qq[i]}) : $signed({1'b0, qq[i]});
         if (d_side.den_zero) xyz_in[i] = '0;
         else if (qsgn[i] > Q_MAX) xyz_in[i] = Q_MAX[15:0];
         else if (qsgn[i] < -Q_MAX) xyz_in[i] = 16'(-Q_MAX);
         else xyz_in[i] = qsgn[i][15:0];
      end
      if (d_side.opp) w_in = '0;
      else if (d_side.w > 16'(Q14_ONE)) w_in = Q14_ONE;
      else w_in = $signed(d_side.w);
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= d_vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (d_side.zero) begin
            quat_w_ff <= Q14_ONE;
            quat_x_ff <= '0;
            quat_y_ff <= '0;
            quat_z_ff <= '0;
            opp_ff    <= 1'b0;
            zero_ff   <= 1'b1;
         end else begin
            quat_w_ff <= w_in;
            quat_x_ff <= xyz_in[0];
            quat_y_ff <= xyz_in[1];
            quat_z_ff <= xyz_in[2];
            opp_ff    <= d_side.opp;
            zero_ff   <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.quat_w        = quat_w_ff;
   assign rsp_ch.quat_x        = quat_x_ff;
   assign rsp_ch.quat_y        = quat_y_ff;
   assign rsp_ch.quat_z        = quat_z_ff;
   assign rsp_ch.opposite_case = opp_ff;
   assign rsp_ch.zero_input    = zero_ff;

   // zero-length input always yields the identity
   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && zero_ff |-> quat_w_ff == Q14_ONE && quat_x_ff == '0
                               && quat_y_ff == '0 && quat_z_ff == '0 && !opp_ff)
      else $error("zero input did not give identity");

   // half turn has no scalar part
   a_opp_w: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && opp_ff |-> quat_w_ff == '0)
      else $error("half turn with nonzero w");

   // regular branch keeps s well away from zero, so w is positive
   a_w_pos: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !opp_ff && !zero_ff |-> quat_w_ff > 0)
      else $error("regular rotation with nonpositive w");

   // a stall freezes the pipeline valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s2_vld_ff) && $stable(s8_vld_ff) && $stable(s9_vld_ff))
      else $error("pipeline moved during stall");

endmodule

// ----- sim/tb_rotation_between_vectors_top.sv -----
// testbench for the rotation-between-vectors block: directed table plus random pairs
`timescale 1ns / 100ps

module tb_rotation_between_vectors_top;
   import rbv_pkg::*;

   typedef struct packed {
      logic signed [15:0] w, x, y, z;
      logic               opp, zero;
   } quat_type;

   typedef struct {
      logic signed [15:0] sv[3];
      logic signed [15:0] dv[3];
      bit                 typed;
      quat_type           q;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   bit   stim_done = 1'b0;
   bit   quiet_mode = 1'b0;
   quat_type quat_queue[$];

   rbv_req_if req_ch();
   rbv_rsp_if rsp_ch();

   rotation_between_vectors_top i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint unsigned mag, q;
      if (d <= 0) return 0;
      mag = (n < 0) ? -n : n;
      q = (mag + longint'(d) / 2) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void to_unit(input longint v[3], output longint u[3]);
      longint unsigned n2;
      longint len;
      n2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      len = root64(n2 << 30);
      for (int i = 0; i < 3; i++) u[i] = clip(round_div(v[i] * (64'sd1 <<< 30), len),
                                              -32768, 32768);
   endfunction

   function automatic quat_type shortest_arc(logic signed [15:0] sv[3],
                                             logic signed [15:0] dv[3]);
      longint s[3], d[3], su[3], du[3], ax[3], q[4];
      longint c, m2, len, s30;
      longint one;
      quat_type r;
      one = 64'sd1 <<< 30;
      for (int i = 0; i < 3; i++) begin
         s[i] = longint'(sv[i]);
         d[i] = longint'(dv[i]);
      end
      r.opp = 1'b0;
      r.zero = 1'b0;
      if ((s[0] == 0 && s[1] == 0 && s[2] == 0) || (d[0] == 0 && d[1] == 0 && d[2] == 0)) begin
         r.w = 16'sd16384; r.x = '0; r.y = '0; r.z = '0; r.zero = 1'b1;
         return r;
      end
      to_unit(s, su);
      to_unit(d, du);
      c = clip(su[0] * du[0] + su[1] * du[1] + su[2] * du[2], -one, one);
      if (c * 1000 < -999 * one) begin
         r.opp = 1'b1;
         ax[0] = -su[1]; ax[1] = su[0]; ax[2] = 0;
         m2 = ax[0] * ax[0] + ax[1] * ax[1];
         // axis too short: use x cross start instead
         if (m2 * 100 < one) begin
            ax[0] = 0; ax[1] = -su[2]; ax[2] = su[1];
            m2 = ax[1] * ax[1] + ax[2] * ax[2];
         end
         len = root64(longint'(m2) << 30);
         q[0] = 0;
         for (int i = 0; i < 3; i++)
            q[1 + i] = (len > 0) ? round_div(ax[i] * (64'sd1 <<< 29), len) : 0;
      end else begin
         s30 = root64(longint'(2 * (one + c)) << 30);
         ax[0] = su[1] * du[2] - su[2] * du[1];
         ax[1] = su[2] * du[0] - su[0] * du[2];
         ax[2] = su[0] * du[1] - su[1] * du[0];
         q[0] = round_div(s30, 64'sd1 <<< 17);
         for (int i = 0; i < 3; i++) q[1 + i] = round_div(ax[i] * (64'sd1 <<< 14), s30);
      end
      r.w = 16'(clip(q[0], -16384, 16384));
      r.x = 16'(clip(q[1], -16384, 16384));
      r.y = 16'(clip(q[2], -16384, 16384));
      r.z = 16'(clip(q[3], -16384, 16384));
      return r;
   endfunction

   function automatic stim_row_type mk(int ax, int ay, int az, int bx, int by, int bz,
                                       bit typed = 0, int w = 0, int x = 0, int y = 0,
                                       int z = 0, bit opp = 0, bit zero = 0);
      stim_row_type r;
      r.sv[0] = 16'(ax); r.sv[1] = 16'(ay); r.sv[2] = 16'(az);
      r.dv[0] = 16'(bx); r.dv[1] = 16'(by); r.dv[2] = 16'(bz);
      r.typed = typed;
      r.q.w = 16'(w); r.q.x = 16'(x); r.q.y = 16'(y); r.q.z = 16'(z);
      r.q.opp = opp; r.q.zero = zero;
      return r;
   endfunction

   task automatic send_pair(stim_row_type r);
      quat_type q;
      while (!quiet_mode && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= r.sv[0]; req_ch.start_y <= r.sv[1]; req_ch.start_z <= r.sv[2];
      req_ch.dest_x  <= r.dv[0]; req_ch.dest_y  <= r.dv[1]; req_ch.dest_z  <= r.dv[2];
      q = shortest_arc(r.sv, r.dv);
      if (r.typed && q != r.q) begin
         $error("directed row disagrees with prediction: w %0d x %0d y %0d z %0d",
                q.w, q.x, q.y, q.z);
         error_count++;
      end
      if (r.typed) q = r.q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      quat_queue.push_back(q);
   endtask

   function automatic logic signed [15:0] rand_comp(int mode);
      unique case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 64)) - 32);
         2: return $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(3))
                                     : 16'(16'sh8000 + $urandom_range(3));
         default: return '0;
      endcase
   endfunction

   initial begin
      stim_row_type table_rows[$];
      stim_row_type r;
      int mode, k;
      req_ch.valid <= 1'b0;
      req_ch.start_x <= '0; req_ch.start_y <= '0; req_ch.start_z <= '0;
      req_ch.dest_x <= '0; req_ch.dest_y <= '0; req_ch.dest_z <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero-length vectors give identity
      table_rows.push_back(mk(0, 0, 0, 1, 2, 3, 1, 16384, 0, 0, 0, 0, 1));
      table_rows.push_back(mk(5, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 0, 1));
      table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 0, 1));
      // same direction gives identity
      table_rows.push_back(mk(1, 0, 0, 32767, 0, 0, 1, 16384, 0, 0, 0, 0, 0));
      // opposite along x: axis z cross x = +y
      table_rows.push_back(mk(1, 0, 0, -1, 0, 0, 1, 0, 0, 16384, 0, 1, 0));
      // opposite along z: fallback axis x cross z = -y
      table_rows.push_back(mk(0, 0, 1, 0, 0, -1, 1, 0, 0, -16384, 0, 1, 0));
      table_rows.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767));
      table_rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
      table_rows.push_back(mk(-32768, 0, 0, 0, -32768, 0));
      table_rows.push_back(mk(1, 0, 0, 0, 1, 0));
      table_rows.push_back(mk(0, 0, -32768, 0, 32767, 0));
      table_rows.push_back(mk(1000, 10, 0, -1000, -9, 1));
      table_rows.push_back(mk(1000, 0, 0, -1000, 45, 0));
      table_rows.push_back(mk(1, 1, 100, -1, -1, -100));
      table_rows.push_back(mk(-1, -1, -1, 1, 1, 1));
      table_rows.push_back(mk(32767, -32768, 1, -1, 0, 32767));
      foreach (table_rows[i]) send_pair(table_rows[i]);
      for (int n = 0; n < 400; n++) begin
         quiet_mode = (n >= 150 && n < 220);
         mode = $urandom_range(3);
         for (int i = 0; i < 3; i++) begin
            k = (mode == 3) ? $urandom_range(2) : mode;
            r.sv[i] = rand_comp(k);
            r.dv[i] = rand_comp(k);
         end
         // near-opposite pairs reach the half-turn branch
         if ($urandom_range(3) == 0)
            for (int i = 0; i < 3; i++)
               r.dv[i] = 16'(-r.sv[i] + $signed($urandom_range(2)) - 1);
         if ($urandom_range(40) == 0) for (int i = 0; i < 3; i++) r.sv[i] = '0;
         r.typed = 0;
         send_pair(r);
      end
      quiet_mode = 1'b0;
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      quat_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (quat_queue.size() == 0) begin
            $error("response transaction with no expectation pending");
            error_count++;
         end else begin
            e = quat_queue.pop_front();
            if (rsp_ch.quat_w !== e.w) begin
               $error("quat_w expected %0d actual %0d", e.w, rsp_ch.quat_w); error_count++;
            end
            if (rsp_ch.quat_x !== e.x) begin
               $error("quat_x expected %0d actual %0d", e.x, rsp_ch.quat_x); error_count++;
            end
            if (rsp_ch.quat_y !== e.y) begin
               $error("quat_y expected %0d actual %0d", e.y, rsp_ch.quat_y); error_count++;
            end
            if (rsp_ch.quat_z !== e.z) begin
               $error("quat_z expected %0d actual %0d", e.z, rsp_ch.quat_z); error_count++;
            end
            if (rsp_ch.opposite_case !== e.opp) begin
               $error("opposite_case expected %0d actual %0d", e.opp, rsp_ch.opposite_case);
               error_count++;
            end
            if (rsp_ch.zero_input !== e.zero) begin
               $error("zero_input expected %0d actual %0d", e.zero, rsp_ch.zero_input);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && quat_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
